>>> sv/wlcs_pkg.sv
// ----------------------------------------------------------------------------
// wlcs_pkg
// Shared constants, types and helpers for the weighted lane chunk scheduler.
// ----------------------------------------------------------------------------
package wlcs_pkg;

    localparam int NUM_LANES   = 8;
    localparam int TABLE_SLOTS = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int LENGTH_BITS = 24;

    localparam int LANE_W   = 3;
    localparam int ENTRY_W  = 3;
    localparam int WEIGHT_W = 8;
    localparam int UNIT_W   = 16;
    localparam int ECNT_W   = 4;
    localparam int SLOT_W   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = NUM_LANES * QUEUE_DEPTH;
    localparam int RAM_AW   = LANE_W + SLOT_W;
    localparam int DESC_W   = 2 * LENGTH_BITS;
    localparam int QUOTA_W  = WEIGHT_W + UNIT_W;

    localparam int CFG_DW = 64;
    localparam int CFG_IW = 2;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_ENTRY_COUNT   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_UNIT_SIZE     = 2'd1;
    localparam logic [CFG_IW-1:0] REG_ENTRY_LANES   = 2'd2;
    localparam logic [CFG_IW-1:0] REG_ENTRY_WEIGHTS = 2'd3;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_SERVE   = 1'b1;

    typedef enum logic [1:0] {
        KIND_CHUNK   = 2'd0,
        KIND_IDLE    = 2'd1,
        KIND_ENQ_OK  = 2'd2,
        KIND_ENQ_REJ = 2'd3
    } kind_t;

    // arbitration pick handed from the scan unit to the top level
    typedef struct packed {
        logic                found;
        logic [ENTRY_W-1:0]  entry;
        logic [LANE_W-1:0]   lane;
        logic [WEIGHT_W-1:0] weight;
    } pick_t;

    function automatic logic [LANE_W-1:0] lane_of(
        input logic [TABLE_SLOTS*LANE_W-1:0] lanes,
        input int                            e
    );
        lane_of = lanes[e*LANE_W +: LANE_W];
    endfunction

    function automatic logic [WEIGHT_W-1:0] weight_of(
        input logic [TABLE_SLOTS*WEIGHT_W-1:0] weights,
        input int                              e
    );
        weight_of = weights[e*WEIGHT_W +: WEIGHT_W];
    endfunction

endpackage

>>> sv/wlcs_ram.sv
// ----------------------------------------------------------------------------
// wlcs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wlcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/wlcs_pick.sv
// ----------------------------------------------------------------------------
// wlcs_pick
// Circular priority scan of the arbitration table from the round-robin pointer.
// ----------------------------------------------------------------------------
module wlcs_pick (
    input  logic [wlcs_pkg::ECNT_W-1:0]                           active,
    input  logic [wlcs_pkg::ENTRY_W-1:0]                          ptr,
    input  logic [wlcs_pkg::TABLE_SLOTS*wlcs_pkg::LANE_W-1:0]     entry_lanes,
    input  logic [wlcs_pkg::TABLE_SLOTS*wlcs_pkg::WEIGHT_W-1:0]   entry_weights,
    input  logic [wlcs_pkg::NUM_LANES-1:0]                        nonempty,
    output wlcs_pkg::pick_t                                       pick
);
    import wlcs_pkg::*;

    logic [ENTRY_W-1:0]     first_pt;
    logic [TABLE_SLOTS-1:0] elig;
    logic [TABLE_SLOTS-1:0] elig_hi;
    logic                   hit_hi;
    logic                   hit_any;
    logic [ENTRY_W-1:0]     e_hi;
    logic [ENTRY_W-1:0]     e_any;
    logic [ENTRY_W-1:0]     e_sel;

    // stale pointer restarts at entry 0
    assign first_pt = ({1'b0, ptr} < active) ? ptr : '0;

    always_comb
    begin
        for (int e = 0; e < TABLE_SLOTS; e++)
        begin
            elig[e] = (ECNT_W'(e) < active)
                   && (weight_of(entry_weights, e) != '0)
                   && nonempty[lane_of(entry_lanes, e)];
            elig_hi[e] = elig[e] && (ENTRY_W'(e) >= first_pt);
        end
    end

    // lowest set bit; wrap to the entries below the pointer when nothing at or past it
    always_comb
    begin
        hit_hi  = 1'b0;
        hit_any = 1'b0;
        e_hi    = '0;
        e_any   = '0;
        for (int e = TABLE_SLOTS - 1; e >= 0; e--)
        begin
            if (elig_hi[e])
            begin
                hit_hi = 1'b1;
                e_hi   = ENTRY_W'(e);
            end
            if (elig[e])
            begin
                hit_any = 1'b1;
                e_any   = ENTRY_W'(e);
            end
        end
    end

    assign e_sel       = hit_hi ? e_hi : e_any;
    assign pick.found  = hit_any;
    assign pick.entry  = e_sel;
    assign pick.lane   = lane_of(entry_lanes, int'(e_sel));
    assign pick.weight = weight_of(entry_weights, int'(e_sel));

endmodule

>>> sv/weighted_lane_chunk_scheduler.sv
// ----------------------------------------------------------------------------
// weighted_lane_chunk_scheduler
// Weighted round-robin chunk scheduler over per-lane descriptor queues.
// ----------------------------------------------------------------------------
// Enqueue: result word in the cycle after accept; busy stays low, one per cycle while no serve is in progress.
// Serve: the descriptor RAM read, then the chunk math into the result word; busy is
//   high in S_CALC, so no new command is accepted during the RAM read.
// Results carry no backpressure: result_valid is a one-cycle strobe.
// Reset: config to defaults, all queues empty, pointer 0. The descriptor RAM
//   is not cleared and needs no clearing pass; only written slots are read.
// ----------------------------------------------------------------------------
module weighted_lane_chunk_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [2:0]                        lane,
    input  logic [wlcs_pkg::LENGTH_BITS-1:0]  message_length,
    input  logic [wlcs_pkg::LENGTH_BITS-1:0]  base_offset,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [wlcs_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [wlcs_pkg::CFG_DW-1:0]       cfg_data,
    // result channel
    output logic                              result_valid,
    output logic [1:0]                        kind,
    output logic [2:0]                        served_lane,
    output logic [2:0]                        entry_index,
    output logic [wlcs_pkg::LENGTH_BITS-1:0]  chunk_offset,
    output logic [wlcs_pkg::LENGTH_BITS-1:0]  chunk_length,
    output logic                              message_done
);
    import wlcs_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration registers
    logic [ECNT_W-1:0]               entry_count_reg;
    logic [UNIT_W-1:0]               unit_size_reg;
    logic [TABLE_SLOTS*LANE_W-1:0]   entry_lanes_reg;
    logic [TABLE_SLOTS*WEIGHT_W-1:0] entry_weights_reg;

    // per-lane queue bookkeeping (descriptors live in the RAM)
    logic [SLOT_W-1:0]      qhead_reg [NUM_LANES];
    logic [QCNT_W-1:0]      qcount_reg [NUM_LANES];
    logic [LENGTH_BITS-1:0] prog_reg [NUM_LANES];
    logic [ENTRY_W-1:0]     ptr_reg;

    // serve context held across the RAM read
    pick_t                  sel_reg;
    logic [QUOTA_W-1:0]     quota_reg;

    // result word registers
    logic                   valid_reg;
    kind_t                  kind_reg;
    logic [LANE_W-1:0]      lane_out_reg;
    logic [ENTRY_W-1:0]     entry_out_reg;
    logic [LENGTH_BITS-1:0] offset_out_reg;
    logic [LENGTH_BITS-1:0] length_out_reg;
    logic                   done_out_reg;

    logic                   accept;
    logic [ECNT_W-1:0]      active;
    logic [NUM_LANES-1:0]   nonempty;
    pick_t                  pick;

    // enqueue path
    logic                   named;
    logic                   enq_ok;
    logic [SLOT_W-1:0]      tail;

    // RAM ports
    logic                   ram_we;
    logic [RAM_AW-1:0]      ram_waddr;
    logic [DESC_W-1:0]      ram_wdata;
    logic [RAM_AW-1:0]      ram_raddr;
    logic [DESC_W-1:0]      ram_rdata;

    // chunk math
    logic [LENGTH_BITS-1:0] c_len;
    logic [LENGTH_BITS-1:0] c_off;
    logic [LENGTH_BITS-1:0] c_prog;
    logic [LENGTH_BITS-1:0] c_rem;
    logic                   c_done;
    logic [LENGTH_BITS-1:0] c_chunk;
    logic [ENTRY_W:0]       ptr_inc;
    logic [ENTRY_W-1:0]     ptr_wrap;

    assign busy   = (state_reg == S_CALC);
    assign accept = start && !busy;

    // active entry count clamped to the table size
    assign active = (entry_count_reg > ECNT_W'(TABLE_SLOTS)) ?
                    ECNT_W'(TABLE_SLOTS) : entry_count_reg;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            nonempty[l] = (qcount_reg[l] != '0);
        end
    end

    wlcs_pick u_pick (
        .active        (active),
        .ptr           (ptr_reg),
        .entry_lanes   (entry_lanes_reg),
        .entry_weights (entry_weights_reg),
        .nonempty      (nonempty),
        .pick          (pick)
    );

    // enqueue: lane must be named by an active entry and have room
    always_comb
    begin
        named = 1'b0;
        for (int e = 0; e < TABLE_SLOTS; e++)
        begin
            if ((ECNT_W'(e) < active) && (lane_of(entry_lanes_reg, e) == lane))
            begin
                named = 1'b1;
            end
        end
    end

    assign enq_ok = named && (int'(lane) < NUM_LANES)
                 && (qcount_reg[lane] < QCNT_W'(QUEUE_DEPTH));
    assign tail   = qhead_reg[lane] + qcount_reg[lane][SLOT_W-1:0];

    assign ram_we    = accept && (operation == OP_ENQUEUE) && enq_ok;
    assign ram_waddr = {lane, tail};
    assign ram_wdata = {message_length, base_offset};
    assign ram_raddr = {pick.lane, qhead_reg[pick.lane]};

    wlcs_ram #(
        .WIDTH (DESC_W),
        .DEPTH (RAM_DEPTH)
    ) u_desc_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // chunk: min(quota, bytes left of the head message)
    assign c_len   = ram_rdata[DESC_W-1:LENGTH_BITS];
    assign c_off   = ram_rdata[LENGTH_BITS-1:0];
    assign c_prog  = prog_reg[sel_reg.lane];
    assign c_rem   = (c_prog <= c_len) ? (c_len - c_prog) : '0;
    assign c_done  = (LENGTH_BITS'(quota_reg) >= c_rem);
    assign c_chunk = c_done ? c_rem : LENGTH_BITS'(quota_reg);

    // round-robin pointer moves past the granting entry
    assign ptr_inc  = {1'b0, sel_reg.entry} + (ENTRY_W+1)'(1);
    assign ptr_wrap = (ptr_inc == active) ? '0 : ptr_inc[ENTRY_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (operation == OP_SERVE))
                begin
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && (operation == OP_SERVE))
        begin
            sel_reg   <= pick;
            quota_reg <= QUOTA_W'(pick.weight) * QUOTA_W'(unit_size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            entry_count_reg   <= ECNT_W'(1);
            unit_size_reg     <= UNIT_W'(1024);
            entry_lanes_reg   <= '0;
            entry_weights_reg <= '0;
            ptr_reg           <= '0;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                qhead_reg[l]  <= '0;
                qcount_reg[l] <= '0;
                prog_reg[l]   <= '0;
            end
            valid_reg      <= 1'b0;
            kind_reg       <= KIND_IDLE;
            lane_out_reg   <= '0;
            entry_out_reg  <= '0;
            offset_out_reg <= '0;
            length_out_reg <= '0;
            done_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // a word leaves after every enqueue and after every serve read
            valid_reg <= (accept && (operation == OP_ENQUEUE)) || (state_reg == S_CALC);

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ENTRY_COUNT:   entry_count_reg   <= cfg_data[ECNT_W-1:0];
                    REG_UNIT_SIZE:     unit_size_reg     <= cfg_data[UNIT_W-1:0];
                    REG_ENTRY_LANES:   entry_lanes_reg   <=
                                           cfg_data[TABLE_SLOTS*LANE_W-1:0];
                    REG_ENTRY_WEIGHTS: entry_weights_reg <=
                                           cfg_data[TABLE_SLOTS*WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // enqueue finishes in the accept cycle
            if (accept && (operation == OP_ENQUEUE))
            begin
                kind_reg       <= enq_ok ? KIND_ENQ_OK : KIND_ENQ_REJ;
                lane_out_reg   <= '0;
                entry_out_reg  <= '0;
                offset_out_reg <= '0;
                length_out_reg <= '0;
                done_out_reg   <= 1'b0;
                if (enq_ok)
                begin
                    qcount_reg[lane] <= qcount_reg[lane] + QCNT_W'(1);
                end
            end

            // serve finishes once the head descriptor is back from the RAM
            if (state_reg == S_CALC)
            begin
                if (sel_reg.found)
                begin
                    kind_reg       <= KIND_CHUNK;
                    lane_out_reg   <= sel_reg.lane;
                    entry_out_reg  <= sel_reg.entry;
                    offset_out_reg <= c_off + c_prog;
                    length_out_reg <= c_chunk;
                    done_out_reg   <= c_done;
                    ptr_reg        <= ptr_wrap;
                    if (c_done)
                    begin
                        qhead_reg[sel_reg.lane]  <= qhead_reg[sel_reg.lane] + SLOT_W'(1);
                        qcount_reg[sel_reg.lane] <= qcount_reg[sel_reg.lane] - QCNT_W'(1);
                        prog_reg[sel_reg.lane]   <= '0;
                    end
                    else
                    begin
                        prog_reg[sel_reg.lane] <= c_prog + c_chunk;
                    end
                end
                else
                begin
                    kind_reg       <= KIND_IDLE;
                    lane_out_reg   <= '0;
                    entry_out_reg  <= '0;
                    offset_out_reg <= '0;
                    length_out_reg <= '0;
                    done_out_reg   <= 1'b0;
                end
            end
        end
    end

    assign result_valid = valid_reg;
    assign kind         = kind_reg;
    assign served_lane  = lane_out_reg;
    assign entry_index  = entry_out_reg;
    assign chunk_offset = offset_out_reg;
    assign chunk_length = length_out_reg;
    assign message_done = done_out_reg;

endmodule

>>> sv/wlcs_checker.sv
// ----------------------------------------------------------------------------
// wlcs_checker
// Port-level timing checks for the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module wlcs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              operation,
    input  logic                              result_valid,
    input  logic [1:0]                        kind,
    input  logic [wlcs_pkg::LENGTH_BITS-1:0]  chunk_offset,
    input  logic [wlcs_pkg::LENGTH_BITS-1:0]  chunk_length,
    input  logic                              message_done
);
    import wlcs_pkg::*;

    // enqueue answers in the next cycle without blocking the command side
    a_enq_answer: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_ENQUEUE) |=>
            result_valid && !busy && (kind == KIND_ENQ_OK || kind == KIND_ENQ_REJ))
        else $error("enqueue word missing or wrong kind");

    // serve blocks in the next cycle with no word in flight
    a_serve_wait: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (operation == OP_SERVE) |=> busy && !result_valid)
        else $error("serve did not hold busy for its read cycle");

    // serve word follows busy and busy drops
    a_serve_answer: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && result_valid && (kind == KIND_CHUNK || kind == KIND_IDLE))
        else $error("serve word missing or wrong kind");

    // non-chunk words carry zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind != KIND_CHUNK) |->
            (chunk_offset == '0) && (chunk_length == '0) && !message_done)
        else $error("non-chunk word carries payload");

endmodule

bind weighted_lane_chunk_scheduler wlcs_checker u_wlcs_checker (.*);

>>> tb/chunk_schedule_checker.sv
// ----------------------------------------------------------------------------
// chunk_schedule_checker
// Watches the command, config and result channels of the chunk scheduler,
// keeps its own copy of the lane queues and arbitration table, and compares
// every result word against the predicted one, oldest first.
// ----------------------------------------------------------------------------
module chunk_schedule_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              operation,
    input  logic [2:0]                        lane,
    input  logic [wlcs_pkg::LENGTH_BITS-1:0]  message_length,
    input  logic [wlcs_pkg::LENGTH_BITS-1:0]  base_offset,
    input  logic                              cfg_wr_en,
    input  logic [wlcs_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [wlcs_pkg::CFG_DW-1:0]       cfg_data,
    input  logic                              result_valid,
    input  logic [1:0]                        kind,
    input  logic [2:0]                        served_lane,
    input  logic [2:0]                        entry_index,
    input  logic [wlcs_pkg::LENGTH_BITS-1:0]  chunk_offset,
    input  logic [wlcs_pkg::LENGTH_BITS-1:0]  chunk_length,
    input  logic                              message_done,
    output int                                fail_count,
    output int                                words_in_flight,
    output int                                queued_messages,
    output int                                chunks_seen,
    output int                                rejects_seen
);
    import wlcs_pkg::*;

    localparam int MAX_REPORTS = 200;

    typedef struct packed {
        kind_t                  kind;
        logic [LANE_W-1:0]      lane;
        logic [ENTRY_W-1:0]     entry;
        logic [LENGTH_BITS-1:0] offset;
        logic [LENGTH_BITS-1:0] length;
        logic                   done;
    } sched_word_t;

    // table registers
    logic [ECNT_W-1:0]               cfg_count;
    logic [UNIT_W-1:0]               cfg_unit;
    logic [TABLE_SLOTS*LANE_W-1:0]   cfg_lanes;
    logic [TABLE_SLOTS*WEIGHT_W-1:0] cfg_weights;

    // lane queues and arbitration state
    logic [LENGTH_BITS-1:0] desc_len [NUM_LANES][QUEUE_DEPTH];
    logic [LENGTH_BITS-1:0] desc_off [NUM_LANES][QUEUE_DEPTH];
    logic [SLOT_W-1:0]      q_head   [NUM_LANES];
    logic [QCNT_W-1:0]      q_count  [NUM_LANES];
    logic [LENGTH_BITS-1:0] progress [NUM_LANES];
    logic [ENTRY_W-1:0]     rr_ptr;

    sched_word_t expected_words [$];

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
        end
    endtask

    // Applies one command word to the model state and returns its result word.
    task automatic schedule_command(output sched_word_t w);
        int                     n;
        int                     first;
        int                     e;
        int                     k;
        bit                     named;
        bit                     found;
        logic [LANE_W-1:0]      ln;
        logic [WEIGHT_W-1:0]    wt;
        logic [SLOT_W-1:0]      h;
        logic [LENGTH_BITS-1:0] len;
        logic [LENGTH_BITS-1:0] prog;
        logic [LENGTH_BITS-1:0] rem;
        logic [QUOTA_W-1:0]     quota;
        w = '0;
        n = (cfg_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(cfg_count);
        if (operation == OP_ENQUEUE)
        begin
            named = 1'b0;
            for (e = 0; e < n; e++)
                if (cfg_lanes[e*LANE_W +: LANE_W] == lane)
                    named = 1'b1;
            if (!named || q_count[lane] >= QUEUE_DEPTH)
                w.kind = KIND_ENQ_REJ;
            else
            begin
                h = q_head[lane] + q_count[lane][SLOT_W-1:0];
                desc_len[lane][h] = message_length;
                desc_off[lane][h] = base_offset;
                q_count[lane]++;
                w.kind = KIND_ENQ_OK;
            end
        end
        else
        begin
            w.kind = KIND_IDLE;
            found  = 1'b0;
            first  = (rr_ptr < n) ? int'(rr_ptr) : 0;
            for (k = 0; k < n && !found; k++)
            begin
                e  = (first + k) % n;
                ln = cfg_lanes[e*LANE_W +: LANE_W];
                wt = cfg_weights[e*WEIGHT_W +: WEIGHT_W];
                if (wt != 0 && q_count[ln] != 0)
                begin
                    found    = 1'b1;
                    h        = q_head[ln];
                    len      = desc_len[ln][h];
                    prog     = progress[ln];
                    rem      = (prog <= len) ? len - prog : '0;
                    quota    = wt * cfg_unit;
                    w.kind   = KIND_CHUNK;
                    w.lane   = ln;
                    w.entry  = ENTRY_W'(e);
                    w.offset = desc_off[ln][h] + prog;
                    if (quota >= rem)
                    begin
                        w.length     = rem;
                        w.done       = 1'b1;
                        q_head[ln]   = h + 1'b1;
                        q_count[ln]--;
                        progress[ln] = '0;
                    end
                    else
                    begin
                        w.length     = quota;
                        progress[ln] = prog + quota;
                    end
                    rr_ptr = ENTRY_W'((e + 1) % n);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_word_t want;
        if (!rst_n)
        begin
            cfg_count   = 4'd1;
            cfg_unit    = 16'd1024;
            cfg_lanes   = '0;
            cfg_weights = '0;
            for (int i = 0; i < NUM_LANES; i++)
            begin
                q_head[i]   = '0;
                q_count[i]  = '0;
                progress[i] = '0;
            end
            rr_ptr = '0;
            expected_words.delete();
            words_in_flight = 0;
            queued_messages = 0;
        end
        else
        begin
            // results first: a word accepted at this edge cannot answer yet
            if (result_valid)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result word with none expected, actual kind %0d",
                                 $time, kind);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("kind", want.kind, kind);
                    check_field("served_lane", want.lane, served_lane);
                    check_field("entry_index", want.entry, entry_index);
                    check_field("chunk_offset", want.offset, chunk_offset);
                    check_field("chunk_length", want.length, chunk_length);
                    check_field("message_done", want.done, message_done);
                    if (want.kind == KIND_CHUNK)
                        chunks_seen++;
                    if (want.kind == KIND_ENQ_REJ)
                        rejects_seen++;
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ENTRY_COUNT:   cfg_count   = cfg_data[ECNT_W-1:0];
                    REG_UNIT_SIZE:     cfg_unit    = cfg_data[UNIT_W-1:0];
                    REG_ENTRY_LANES:   cfg_lanes   = cfg_data[TABLE_SLOTS*LANE_W-1:0];
                    REG_ENTRY_WEIGHTS: cfg_weights = cfg_data[TABLE_SLOTS*WEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                schedule_command(want);
                expected_words.insert(expected_words.size(), want);
            end
            words_in_flight = expected_words.size();
            queued_messages = 0;
            for (int i = 0; i < NUM_LANES; i++)
                queued_messages += q_count[i];
        end
    end

endmodule

>>> tb/weighted_lane_chunk_scheduler_tb.sv
// ----------------------------------------------------------------------------
// weighted_lane_chunk_scheduler_tb
// Drives enqueue and serve commands through a series of arbitration tables,
// with random sender gaps, and lets the checker predict and compare each
// result word. Prints the verdict at the end.
// ----------------------------------------------------------------------------
module weighted_lane_chunk_scheduler_tb;
    import wlcs_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int PHASE_ITEMS = 120;
    localparam int IDLE_PCT    = 29;
    // entry i -> lane i
    localparam logic [23:0] IDENTITY_LANES = 24'hFAC688;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   operation = OP_ENQUEUE;
    logic [2:0]             lane = '0;
    logic [LENGTH_BITS-1:0] message_length = '0;
    logic [LENGTH_BITS-1:0] base_offset = '0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0]      cfg_index = REG_ENTRY_COUNT;
    logic [CFG_DW-1:0]      cfg_data = '0;
    logic                   result_valid;
    logic [1:0]             kind;
    logic [2:0]             served_lane;
    logic [2:0]             entry_index;
    logic [LENGTH_BITS-1:0] chunk_offset;
    logic [LENGTH_BITS-1:0] chunk_length;
    logic                   message_done;

    int fail_count;
    int words_in_flight;
    int queued_messages;
    int chunks_seen;
    int rejects_seen;

    // sender-side view of the current table, used to aim enqueues at lanes
    // that some active entry names
    int          cur_active;
    logic [15:0] cur_unit;
    logic [23:0] cur_lanes;
    bit          long_msgs;
    bit          idling_on = 1'b1;
    int          words_sent;
    int          table_loads;

    always #5 clk = ~clk;

    weighted_lane_chunk_scheduler i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .lane           (lane),
        .message_length (message_length),
        .base_offset    (base_offset),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .kind           (kind),
        .served_lane    (served_lane),
        .entry_index    (entry_index),
        .chunk_offset   (chunk_offset),
        .chunk_length   (chunk_length),
        .message_done   (message_done)
    );

    chunk_schedule_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .lane            (lane),
        .message_length  (message_length),
        .base_offset     (base_offset),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .result_valid    (result_valid),
        .kind            (kind),
        .served_lane     (served_lane),
        .entry_index     (entry_index),
        .chunk_offset    (chunk_offset),
        .chunk_length    (chunk_length),
        .message_done    (message_done),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight),
        .queued_messages (queued_messages),
        .chunks_seen     (chunks_seen),
        .rejects_seen    (rejects_seen)
    );

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5000000;
        $display("%0t: run timed out", $time);
        $display("*** FAILED ***");
        $finish;
    end

    // One register write per clock; the caller drops the enable afterwards.
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    // Loads all four registers. Bits above each register's width carry junk
    // so the masking in the block gets exercised too.
    task automatic load_table(input logic [3:0] count, input logic [15:0] unit,
                              input logic [23:0] lanes, input logic [63:0] weights);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_ENTRY_COUNT, {junk[63:4], count});
        junk = {$urandom, $urandom};
        write_reg(REG_UNIT_SIZE, {junk[63:16], unit});
        junk = {$urandom, $urandom};
        write_reg(REG_ENTRY_LANES, {junk[63:24], lanes});
        write_reg(REG_ENTRY_WEIGHTS, weights);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_active = (count > 8) ? 8 : int'(count);
        cur_unit   = unit;
        cur_lanes  = lanes;
        long_msgs  = (unit >= 16'd8192);
        table_loads++;
    endtask

    // Sends one command word, optionally after a random gap, and returns on
    // the edge that accepts it. start is left high so back-to-back words
    // need no extra low cycle.
    task automatic send(input logic op, input logic [2:0] ln,
                        input logic [23:0] len, input logic [23:0] off);
        int gap;
        gap = 0;
        // each cycle idles with the same odds, so gaps come out geometric
        if (idling_on)
            while ($urandom_range(0, 99) < IDLE_PCT)
                gap++;
        if (gap != 0)
        begin
            @(negedge clk);
            start          <= 1'b0;
            operation      <= 1'($urandom);
            lane           <= 3'($urandom);
            message_length <= 24'($urandom);
            base_offset    <= 24'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start          <= 1'b1;
        operation      <= op;
        lane           <= ln;
        message_length <= len;
        base_offset    <= off;
        @(posedge clk);
        while (busy) @(posedge clk);
        words_sent++;
    endtask

    // Holds the sender until every predicted result word has come back.
    task automatic pause_for_results();
        @(negedge clk);
        start <= 1'b0;
        while (words_in_flight != 0 || busy) @(negedge clk);
    endtask

    // Empties every lane with a table that serves all lanes at full quota,
    // so long messages from a coarse table never clog the next phase.
    task automatic flush_queues();
        pause_for_results();
        load_table(4'd8, 16'hFFFF, IDENTITY_LANES, {8{8'hFF}});
        while (queued_messages != 0)
        begin
            send(OP_SERVE, 3'($urandom), 24'($urandom), 24'($urandom));
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Weights: mostly small so messages span several chunks, some zero.
    function automatic logic [63:0] random_weights();
        logic [63:0] w;
        int          r;
        for (int i = 0; i < 8; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                w[8*i +: 8] = 8'd0;
            else if (r < 85)
                w[8*i +: 8] = 8'($urandom_range(1, 4));
            else
                w[8*i +: 8] = 8'($urandom);
        end
        return w;
    endfunction

    task automatic random_command(input int enq_pct);
        logic [2:0]  ln;
        logic [23:0] len;
        logic [23:0] off;
        int          r;
        ln = 3'($urandom);
        if (cur_active != 0 && $urandom_range(0, 99) < 85)
            ln = cur_lanes[3*$urandom_range(0, cur_active - 1) +: 3];
        r = $urandom_range(0, 99);
        if (r < 8)
            len = '0;
        else if (long_msgs && r < 20)
            len = 24'($urandom);
        else if (long_msgs && r < 24)
            len = '1;
        else
            len = 24'($urandom_range(0, 6 * cur_unit));
        // offsets near the top of the range make chunk offsets wrap
        if ($urandom_range(0, 99) < 10)
            off = 24'hFFFFFF - 24'($urandom_range(0, 4 * cur_unit));
        else
            off = 24'($urandom);
        if ($urandom_range(0, 99) < enq_pct)
            send(OP_ENQUEUE, ln, len, off);
        else
            send(OP_SERVE, ln, len, off);
    endtask

    initial
    begin
        int          phase;
        int          enq_pct;
        logic [3:0]  count;
        logic [15:0] unit;
        logic [23:0] lanes;
        logic [63:0] weights;

        // reset-time table: one entry, lane 0, weight 0
        cur_active = 1;
        cur_unit   = 16'd1024;
        cur_lanes  = '0;
        long_msgs  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        idling_on = 1'b0;
        // nothing queued at all
        send(OP_SERVE, 3'd0, '0, '0);
        // zero-weight entry still admits its lane; empty message at top offset
        send(OP_ENQUEUE, 3'd0, 24'd0, 24'hFFFFFF);
        // lane not named by any active entry
        send(OP_ENQUEUE, 3'd5, 24'd1, 24'd0);
        // only entry has weight zero, so nothing is served
        send(OP_SERVE, 3'd0, '0, '0);

        // no active entries: all enqueues refused, all serves idle
        pause_for_results();
        load_table(4'd0, 16'hFFFF, IDENTITY_LANES, 64'h0101_0101_0101_01FF);
        send(OP_ENQUEUE, 3'd0, 24'd7, 24'd7);
        send(OP_SERVE, 3'd0, '0, '0);

        // full table, entry 0 at the largest weight and unit
        pause_for_results();
        load_table(4'd8, 16'hFFFF, IDENTITY_LANES, 64'h0101_0101_0101_01FF);
        // the zero-length message goes out as one empty, finished chunk
        send(OP_SERVE, 3'd0, '0, '0);
        // maximum message at maximum offset: two chunks, second offset wraps
        send(OP_ENQUEUE, 3'd0, 24'hFFFFFF, 24'hFFFFFF);
        send(OP_SERVE, 3'd0, '0, '0);
        send(OP_SERVE, 3'd0, '0, '0);
        // fill lane 3 past its depth; the last one is refused
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send(OP_ENQUEUE, 3'd3, 24'(i * 3), 24'(i << 20));

        // ---- random phases, each on a fresh table ----
        phase = 0;
        while (words_sent < ITEM_TARGET)
        begin
            flush_queues();
            pause_for_results();
            lanes   = 24'($urandom);
            weights = random_weights();
            case (phase)
                0:
                begin
                    count = 4'd8;
                    unit  = 16'($urandom_range(1, 64));
                end
                1:
                begin
                    // above eight: clamps to eight entries
                    count = 4'($urandom_range(9, 15));
                    unit  = 16'($urandom);
                end
                2:
                begin
                    count = 4'd0;
                    unit  = 16'($urandom_range(1, 64));
                end
                3:
                begin
                    count = 4'd1;
                    unit  = 16'd1;
                    lanes = 24'hFFFFFF;
                end
                4:
                begin
                    count   = 4'd8;
                    unit    = 16'hFFFF;
                    weights = {$urandom, $urandom};
                end
                default:
                begin
                    if ($urandom_range(0, 3) == 0)
                        count = 4'($urandom_range(9, 15));
                    else
                        count = 4'($urandom_range(1, 8));
                    if ($urandom_range(0, 99) < 30)
                        unit = 16'($urandom);
                    else
                        unit = 16'($urandom_range(1, 64));
                end
            endcase
            load_table(count, unit, lanes, weights);
            // one phase runs with the sender never idling
            idling_on = (phase != 5);
            // every third phase leans on enqueues so queues fill up
            enq_pct = (phase % 3 == 0) ? 70 : $urandom_range(35, 60);
            repeat (PHASE_ITEMS) random_command(enq_pct);
            phase++;
        end
        flush_queues();

        // drain, then idle on for any stray word
        pause_for_results();
        repeat (8) @(negedge clk);

        $display("Run covered %0d command words over %0d table loads,", words_sent,
                 table_loads);
        $display("with %0d chunks served, %0d enqueues refused, %0d mismatches.",
                 chunks_seen, rejects_seen, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
